>>> hw/rtl/mtfct_pkg.sv
`default_nettype none

package mtfct_pkg;

	localparam int KIND_W   = 3;
	localparam int ID_W     = 64;
	localparam int CON_W    = 48;
	localparam int RANK_W   = 4;
	localparam int ECNT_W   = 5;
	localparam int STATUS_W = 2;

	localparam int ENTRIES_DEF      = 16;
	localparam int ID_BITS_DEF      = 64;
	localparam int CONTACT_BITS_DEF = 48;

	localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
	localparam logic [KIND_W-1:0] KIND_TOUCH  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd3;
	localparam logic [KIND_W-1:0] KIND_RANK   = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} state_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_LOAD,
		OP_PREV,
		OP_NEXT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     cmp_en;
		logic     live;
	} cell_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/mtfct_if.sv
`default_nettype none

interface mtfct_cmd_if;
	logic                             valid;
	logic                             ready;
	logic [mtfct_pkg::KIND_W-1:0]     kind;
	logic [mtfct_pkg::ID_W-1:0]       node_id;
	logic [mtfct_pkg::CON_W-1:0]      contact_data;
	logic [mtfct_pkg::RANK_W-1:0]     rank;

	modport source (output valid, kind, node_id, contact_data, rank, input ready);
	modport sink (input valid, kind, node_id, contact_data, rank, output ready);
endinterface

interface mtfct_rsp_if;
	logic                             valid;
	logic                             ready;
	logic                             hit;
	logic [mtfct_pkg::ID_W-1:0]       id_out;
	logic [mtfct_pkg::CON_W-1:0]      contact_out;
	logic [mtfct_pkg::ECNT_W-1:0]     entry_count;
	logic [mtfct_pkg::STATUS_W-1:0]   status;

	modport source (output valid, hit, id_out, contact_out, entry_count, status, input ready);
	modport sink (input valid, hit, id_out, contact_out, entry_count, status, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/move_to_front_contact_table_unit.sv
`default_nettype none

// Channel  Role    Beat fields
// cmd      sink    kind, node_id, contact_data, rank
// rsp      source  hit, id_out, contact_out, entry_count, status
//
// Each command runs as a compare step that checks the key in every cell at once, then an
// update step that shifts the cells by a single position and registers the response.
// A new command is taken in the cycle its predecessor finishes, so commands follow one another
// without a gap while rsp keeps up; a stalled response holds the update step.
// Reset empties the table at once; the cell contents are not cleared.

module move_to_front_contact_table_unit #(
	parameter int ENTRIES      = mtfct_pkg::ENTRIES_DEF,
	parameter int ID_BITS      = mtfct_pkg::ID_BITS_DEF,
	parameter int CONTACT_BITS = mtfct_pkg::CONTACT_BITS_DEF
) (
	input wire          clk,
	input wire          arst_n,
	mtfct_cmd_if.sink   cmd,
	mtfct_rsp_if.source rsp
);

	localparam int CS    = (CONTACT_BITS < mtfct_pkg::CON_W) ? CONTACT_BITS : mtfct_pkg::CON_W;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int IDX_W = $clog2(ENTRIES);

	mtfct_pkg::state_t state_q, state_d;

	logic [mtfct_pkg::KIND_W-1:0] kind_q;
	logic [ID_BITS-1:0]           key_q;
	logic [CS-1:0]                con_in_q;
	logic [mtfct_pkg::RANK_W-1:0] rank_q;
	logic [CNT_W-1:0]             count_q, count_d;

	logic                             rsp_valid_q;
	logic                             hit_q;
	logic [mtfct_pkg::ID_W-1:0]       id_out_q;
	logic [mtfct_pkg::CON_W-1:0]      con_out_q;
	logic [mtfct_pkg::ECNT_W-1:0]     ecnt_q;
	logic [mtfct_pkg::STATUS_W-1:0]   status_q;

	logic [ID_BITS-1:0]   id_a  [ENTRIES];
	logic [CS-1:0]        con_a [ENTRIES];
	logic [ENTRIES-1:0]   match_v;
	logic [ENTRIES-1:0]   live_v;
	logic [ENTRIES-1:0]   sel_v;
	mtfct_pkg::cell_ctl_t ctl_a [ENTRIES];

	logic             out_free, upd, cmp, take;
	logic             hit, found, full, do_front, do_close;
	logic [IDX_W-1:0] pos, front_p;
	logic [ID_BITS-1:0] sel_id, load_id;
	logic [CS-1:0]      sel_con, load_con;

	logic                           r_hit;
	logic [ID_BITS-1:0]             r_id;
	logic [CS-1:0]                  r_con;
	logic [mtfct_pkg::STATUS_W-1:0] r_status;

	assign out_free = !rsp_valid_q || rsp.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			mtfct_pkg::ST_IDLE: begin
				if (cmd.valid) begin
					state_d = mtfct_pkg::ST_CMP;
				end
			end
			mtfct_pkg::ST_CMP: begin
				state_d = mtfct_pkg::ST_UPD;
			end
			mtfct_pkg::ST_UPD: begin
				if (out_free) begin
					state_d = cmd.valid ? mtfct_pkg::ST_CMP : mtfct_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mtfct_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmp       = 1'b0;
		upd       = 1'b0;
		cmd.ready = 1'b0;
		case (state_q)
			mtfct_pkg::ST_IDLE: begin
				cmd.ready = 1'b1;
			end
			mtfct_pkg::ST_CMP: begin
				cmp = 1'b1;
			end
			mtfct_pkg::ST_UPD: begin
				upd       = out_free;
				cmd.ready = out_free;
			end
			default: begin
				cmd.ready = 1'b0;
			end
		endcase
	end

	assign take = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtfct_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_q   <= cmd.kind;
			key_q    <= cmd.node_id[ID_BITS-1:0];
			con_in_q <= cmd.contact_data[CS-1:0];
			rank_q   <= cmd.rank;
		end
	end

	always_comb begin
		pos     = '0;
		sel_id  = '0;
		sel_con = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			live_v[i] = CNT_W'(i) < count_q;
			sel_v[i]  = (kind_q == mtfct_pkg::KIND_RANK)
				? (live_v[i] && (i < 2 ** mtfct_pkg::RANK_W)
					&& (rank_q == mtfct_pkg::RANK_W'(i)))
				: match_v[i];
			pos     = pos | (match_v[i] ? IDX_W'(i) : '0);
			sel_id  = sel_id | ({ID_BITS{sel_v[i]}} & id_a[i]);
			sel_con = sel_con | ({CS{sel_v[i]}} & con_a[i]);
		end
	end

	assign hit   = |match_v;
	assign found = |sel_v;
	assign full  = count_q == CNT_W'(ENTRIES);

	assign do_front = upd && (((kind_q == mtfct_pkg::KIND_ADD) && (hit || !full))
		|| ((kind_q == mtfct_pkg::KIND_TOUCH) && hit));
	assign do_close = upd && (kind_q == mtfct_pkg::KIND_REMOVE) && hit;
	assign front_p  = hit ? pos : IDX_W'(count_q);
	assign load_id  = key_q;
	assign load_con = (kind_q == mtfct_pkg::KIND_ADD) ? con_in_q : sel_con;

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			ctl_a[i].cmp_en = cmp;
			ctl_a[i].live   = live_v[i];
			ctl_a[i].op     = mtfct_pkg::OP_HOLD;
			if (do_front) begin
				if (i == 0) begin
					ctl_a[i].op = mtfct_pkg::OP_LOAD;
				end else if (IDX_W'(i) <= front_p) begin
					ctl_a[i].op = mtfct_pkg::OP_PREV;
				end
			end else if (do_close) begin
				if ((IDX_W'(i) >= pos) && (CNT_W'(i + 1) < count_q)) begin
					ctl_a[i].op = mtfct_pkg::OP_NEXT;
				end
			end
		end
	end

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		localparam int PI = (g == 0) ? 0 : g - 1;
		localparam int NI = (g == ENTRIES - 1) ? g : g + 1;

		mtfct_cell #(
			.ID_BITS  (ID_BITS),
			.CON_BITS (CS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl_a[g]),
			.key      (key_q),
			.load_id  (load_id),
			.load_con (load_con),
			.prev_id  (id_a[PI]),
			.prev_con (con_a[PI]),
			.next_id  (id_a[NI]),
			.next_con (con_a[NI]),
			.id       (id_a[g]),
			.con      (con_a[g]),
			.match    (match_v[g])
		);
	end

	always_comb begin
		count_d  = count_q;
		r_hit    = 1'b0;
		r_id     = '0;
		r_con    = '0;
		r_status = mtfct_pkg::STATUS_NOTFOUND;
		case (kind_q)
			mtfct_pkg::KIND_ADD: begin
				if (hit || !full) begin
					r_hit    = hit;
					r_id     = key_q;
					r_con    = con_in_q;
					r_status = mtfct_pkg::STATUS_OK;
					if (!hit) begin
						count_d = count_q + CNT_W'(1);
					end
				end else begin
					r_status = mtfct_pkg::STATUS_FULL;
				end
			end
			mtfct_pkg::KIND_REMOVE, mtfct_pkg::KIND_TOUCH, mtfct_pkg::KIND_LOOKUP: begin
				if (hit) begin
					r_hit    = 1'b1;
					r_id     = key_q;
					r_con    = sel_con;
					r_status = mtfct_pkg::STATUS_OK;
					if (kind_q == mtfct_pkg::KIND_REMOVE) begin
						count_d = count_q - CNT_W'(1);
					end
				end
			end
			mtfct_pkg::KIND_RANK: begin
				if (found) begin
					r_hit    = 1'b1;
					r_id     = sel_id;
					r_con    = sel_con;
					r_status = mtfct_pkg::STATUS_OK;
				end
			end
			default: begin
				r_status = mtfct_pkg::STATUS_NOTFOUND;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (upd) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			hit_q     <= r_hit;
			id_out_q  <= mtfct_pkg::ID_W'(r_id);
			con_out_q <= mtfct_pkg::CON_W'(r_con);
			ecnt_q    <= mtfct_pkg::ECNT_W'(count_d);
			status_q  <= r_status;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.hit         = hit_q;
	assign rsp.id_out      = id_out_q;
	assign rsp.contact_out = con_out_q;
	assign rsp.entry_count = ecnt_q;
	assign rsp.status      = status_q;

	a_match_unique: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mtfct_pkg::ST_UPD) |-> $onehot0(match_v))
		else $error("more than one cell matches the key");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ENTRIES))
		else $error("entry count beyond table size");

	a_count_only_on_update: assert property (@(posedge clk) disable iff (!arst_n)
		!upd |=> $stable(count_q))
		else $error("entry count changed outside the update step");

	a_full_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (status_q == mtfct_pkg::STATUS_FULL)) |-> full)
		else $error("full status reported on a table that is not full");

	a_update_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		upd |=> rsp_valid_q)
		else $error("update step left no response beat");

endmodule

`default_nettype wire

>>> hw/rtl/mtfct_cell.sv
`default_nettype none

module mtfct_cell #(
	parameter int ID_BITS  = mtfct_pkg::ID_BITS_DEF,
	parameter int CON_BITS = mtfct_pkg::CONTACT_BITS_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  mtfct_pkg::cell_ctl_t       ctl,
	input  wire  [ID_BITS-1:0]         key,
	input  wire  [ID_BITS-1:0]         load_id,
	input  wire  [CON_BITS-1:0]        load_con,
	input  wire  [ID_BITS-1:0]         prev_id,
	input  wire  [CON_BITS-1:0]        prev_con,
	input  wire  [ID_BITS-1:0]         next_id,
	input  wire  [CON_BITS-1:0]        next_con,
	output logic [ID_BITS-1:0]         id,
	output logic [CON_BITS-1:0]        con,
	output logic                       match
);

	logic [ID_BITS-1:0]  id_q;
	logic [CON_BITS-1:0] con_q;
	logic                match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.cmp_en) begin
			match_q <= ctl.live && (id_q == key);
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			mtfct_pkg::OP_LOAD: begin
				id_q  <= load_id;
				con_q <= load_con;
			end
			mtfct_pkg::OP_PREV: begin
				id_q  <= prev_id;
				con_q <= prev_con;
			end
			mtfct_pkg::OP_NEXT: begin
				id_q  <= next_id;
				con_q <= next_con;
			end
			default: begin
				id_q  <= id_q;
				con_q <= con_q;
			end
		endcase
	end

	assign id    = id_q;
	assign con   = con_q;
	assign match = match_q;

endmodule

`default_nettype wire
